// ===== src/ltfd_pkg.sv =====
// ltfd_pkg: sizes, command codes and status codes of the list threshold filter delete unit
// used by ltfd_cmp, the top module and the testbench; no dependencies
package ltfd_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int DATA_W = 32;
   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int SIZE_W = 6;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic DIR_AT_OR_BELOW = 1'b0;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [ADDR_W-1:0] addr_type;

endpackage

// ===== src/ltfd_ram.sv =====
// ltfd_ram: generic single write port, single read port ram with registered read data
// no dependencies
module ltfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ltfd_cmp.sv =====
// ltfd_cmp: shared signed compare unit that decides whether an entry is removed
// depends on ltfd_pkg for the data type and direction code
module ltfd_cmp (
   input  ltfd_pkg::data_type entry,
   input  ltfd_pkg::data_type threshold,
   input  logic               direction,
   output logic               hit
);

   always_comb begin
      if (direction == ltfd_pkg::DIR_AT_OR_BELOW) begin
         hit = (entry <= threshold);
      end else begin
         hit = (entry >= threshold);
      end
   end

endmodule

// ===== src/list_threshold_filter_delete_unit.sv =====
// list_threshold_filter_delete_unit: ordered list with append, read-out and filter delete
// depends on ltfd_pkg, ltfd_ram (entry store) and ltfd_cmp (shared compare unit)
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+---------------------------
//   request  | req_command, req_value, req_direction         | start high, busy low
//   response | rsp_status, rsp_item, rsp_final_res,          | rsp_valid strobe, one cycle
//            | rsp_size_now                                  |
//
// append and empty-list commands: response on the next cycle
// read-out and filter delete: busy for the scan and drain states, one ram read per entry,
// compare unit and ram port used once per entry; responses registered after ram read
// reset clears the fill count, sequencer and strobe; entries are undefined until written
// the receiver cannot stall: every response word is shown for one cycle only
module list_threshold_filter_delete_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic signed [31:0] req_value,
   input  logic        req_direction,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic signed [31:0] rsp_item,
   output logic        rsp_final_res,
   output logic [5:0]  rsp_size_now
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0] state_ff, state_in;
   ltfd_pkg::count_type fill_ff, fill_in;
   ltfd_pkg::count_type kept_ff, kept_in;
   ltfd_pkg::addr_type idx_ff, idx_in;
   logic dv_ff, dv_in;
   logic dv_last_ff, dv_last_in;
   logic [1:0] op_ff, op_in;
   ltfd_pkg::data_type thr_ff, thr_in;
   logic dir_ff, dir_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   ltfd_pkg::data_type rsp_item_ff, rsp_item_in;
   logic rsp_final_ff, rsp_final_in;
   logic [ltfd_pkg::SIZE_W-1:0] rsp_size_ff, rsp_size_in;

   logic wr_en;
   ltfd_pkg::addr_type wr_addr;
   ltfd_pkg::data_type wr_data;
   logic [ltfd_pkg::DATA_W-1:0] rd_data;
   ltfd_pkg::data_type entry;
   logic hit;
   logic accept;
   ltfd_pkg::count_type kept_next;

   ltfd_ram #(
      .WIDTH(ltfd_pkg::DATA_W),
      .DEPTH(ltfd_pkg::LIST_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign entry = rd_data;

   ltfd_cmp u_cmp (
      .entry    (entry),
      .threshold(thr_ff),
      .direction(dir_ff),
      .hit      (hit)
   );

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign kept_next = kept_ff + ltfd_pkg::CNT_W'(!hit);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      kept_in = kept_ff;
      idx_in = idx_ff;
      dv_in = 1'b0;
      dv_last_in = 1'b0;
      op_in = op_ff;
      thr_in = thr_ff;
      dir_in = dir_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_item_in = rsp_item_ff;
      rsp_final_in = rsp_final_ff;
      rsp_size_in = rsp_size_ff;
      wr_en = 1'b0;
      wr_addr = fill_ff[ltfd_pkg::ADDR_W-1:0];
      wr_data = req_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_command == ltfd_pkg::CMD_APPEND) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in = req_value;
                  rsp_final_in = 1'b1;
                  if (fill_ff == ltfd_pkg::CNT_W'(ltfd_pkg::LIST_DEPTH)) begin
                     rsp_status_in = ltfd_pkg::ST_FULL;
                     rsp_size_in = ltfd_pkg::SIZE_W'(fill_ff);
                  end else begin
                     wr_en = 1'b1;
                     fill_in = fill_ff + ltfd_pkg::CNT_W'(1);
                     rsp_status_in = ltfd_pkg::ST_OK;
                     rsp_size_in = ltfd_pkg::SIZE_W'(fill_in);
                  end
               end else if (req_command == ltfd_pkg::CMD_READ ||
                            req_command == ltfd_pkg::CMD_DELETE) begin
                  if (fill_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = ltfd_pkg::ST_EMPTY;
                     rsp_item_in = '0;
                     rsp_final_in = 1'b1;
                     rsp_size_in = '0;
                  end else begin
                     state_in = S_SCAN;
                     op_in = req_command;
                     thr_in = req_value;
                     dir_in = req_direction;
                     idx_in = '0;
                     kept_in = '0;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            dv_in = 1'b1;
            idx_in = idx_ff + ltfd_pkg::ADDR_W'(1);
            if (ltfd_pkg::CNT_W'(idx_ff) == fill_ff - ltfd_pkg::CNT_W'(1)) begin
               dv_last_in = 1'b1;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // data word from the ram, one per entry
      if (dv_ff) begin
         if (op_ff == ltfd_pkg::CMD_READ) begin
            rsp_valid_in = 1'b1;
            rsp_status_in = ltfd_pkg::ST_OK;
            rsp_item_in = entry;
            rsp_final_in = dv_last_ff;
            rsp_size_in = ltfd_pkg::SIZE_W'(fill_ff);
         end else begin
            if (!hit) begin
               wr_en = 1'b1;
               wr_addr = kept_ff[ltfd_pkg::ADDR_W-1:0];
               wr_data = entry;
            end
            kept_in = kept_next;
            if (dv_last_ff) begin
               fill_in = kept_next;
               rsp_valid_in = 1'b1;
               rsp_status_in = ltfd_pkg::ST_OK;
               rsp_item_in = ltfd_pkg::DATA_W'(fill_ff - kept_next);
               rsp_final_in = 1'b1;
               rsp_size_in = ltfd_pkg::SIZE_W'(kept_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         dv_ff <= 1'b0;
         dv_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         dv_ff <= dv_in;
         dv_last_ff <= dv_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kept_ff <= kept_in;
      idx_ff <= idx_in;
      op_ff <= op_in;
      thr_ff <= thr_in;
      dir_ff <= dir_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff <= rsp_item_in;
      rsp_final_ff <= rsp_final_in;
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item = rsp_item_ff;
   assign rsp_final_res = rsp_final_ff;
   assign rsp_size_now = rsp_size_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= ltfd_pkg::CNT_W'(ltfd_pkg::LIST_DEPTH))
      else $error("fill count beyond list depth");

   a_data_in_scan: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (state_ff == S_SCAN || state_ff == S_DRAIN))
      else $error("ram data word outside a scan");

   a_append_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == ltfd_pkg::CMD_APPEND) |=> (rsp_valid && rsp_final_res))
      else $error("append without a final response");

   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ltfd_pkg::ST_EMPTY) |-> (rsp_size_now == '0 && rsp_final_res))
      else $error("empty status with entries held");

endmodule

// ===== verif/tb_list_threshold_filter_delete_unit.sv =====
`timescale 1ns / 100ps
// tb_list_threshold_filter_delete_unit: self-checking testbench for the list filter delete unit
// drives append, read-out and filter delete words against a shadow copy of the list
// depends on ltfd_pkg and list_threshold_filter_delete_unit
module tb_list_threshold_filter_delete_unit;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 2 * ltfd_pkg::LIST_DEPTH + 8;
   localparam int PRINT_CAP = 30;

   typedef struct {
      logic [1:0]         status;
      ltfd_pkg::data_type item;
      logic               final_res;
      logic [5:0]         size_now;
   } answer_word_type;

   class list_mirror_type;
      ltfd_pkg::data_type shadow_entries[ltfd_pkg::LIST_DEPTH];
      int unsigned        shadow_fill;
      answer_word_type    due_words[$];
      int                 errors;
      int                 words_checked;
      int                 commands_seen;
      int                 full_drops;
      int                 deletes_seen;

      function new();
         shadow_fill = 0;
         errors = 0;
         words_checked = 0;
         commands_seen = 0;
         full_drops = 0;
         deletes_seen = 0;
      endfunction

      function int waiting();
         return due_words.size();
      endfunction

      function int unsigned fill_level();
         return shadow_fill;
      endfunction

      function ltfd_pkg::data_type sample_entry();
         if (shadow_fill == 0) begin
            return '0;
         end
         return shadow_entries[$urandom_range(shadow_fill - 1)];
      endfunction

      function void queue_word(logic [1:0] status, ltfd_pkg::data_type item, logic fin,
                               int unsigned size);
         answer_word_type w;
         w.status = status;
         w.item = item;
         w.final_res = fin;
         w.size_now = size[5:0];
         due_words.push_back(w);
      endfunction

      function void note_command(logic [1:0] cmd, ltfd_pkg::data_type val, logic dir);
         int unsigned        kept;
         ltfd_pkg::data_type e;
         logic               hit;
         unique case (cmd)
            ltfd_pkg::CMD_APPEND: begin
               commands_seen++;
               if (shadow_fill >= ltfd_pkg::LIST_DEPTH) begin
                  full_drops++;
                  queue_word(ltfd_pkg::ST_FULL, val, 1'b1, shadow_fill);
               end else begin
                  shadow_entries[shadow_fill] = val;
                  shadow_fill++;
                  queue_word(ltfd_pkg::ST_OK, val, 1'b1, shadow_fill);
               end
            end
            ltfd_pkg::CMD_READ: begin
               commands_seen++;
               if (shadow_fill == 0) begin
                  queue_word(ltfd_pkg::ST_EMPTY, '0, 1'b1, 0);
               end else begin
                  for (int i = 0; i < shadow_fill; i++) begin
                     queue_word(ltfd_pkg::ST_OK, shadow_entries[i], (i == shadow_fill - 1),
                                shadow_fill);
                  end
               end
            end
            ltfd_pkg::CMD_DELETE: begin
               commands_seen++;
               deletes_seen++;
               if (shadow_fill == 0) begin
                  queue_word(ltfd_pkg::ST_EMPTY, '0, 1'b1, 0);
               end else begin
                  kept = 0;
                  for (int i = 0; i < shadow_fill; i++) begin
                     e = shadow_entries[i];
                     hit = (dir == ltfd_pkg::DIR_AT_OR_BELOW) ? (e <= val) : (e >= val);
                     if (!hit) begin
                        shadow_entries[kept] = e;
                        kept++;
                     end
                  end
                  queue_word(ltfd_pkg::ST_OK, ltfd_pkg::data_type'(shadow_fill - kept), 1'b1,
                             kept);
                  shadow_fill = kept;
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report(string msg);
         if (errors < PRINT_CAP) begin
            $display("%0t mismatch: %s", $time, msg);
         end
         errors++;
      endtask

      task check_word(logic [1:0] status, ltfd_pkg::data_type item, logic fin,
                      logic [5:0] size);
         answer_word_type w;
         if (due_words.size() == 0) begin
            report($sformatf("unexpected word status %0d item %0d", status, item));
            return;
         end
         w = due_words.pop_front();
         words_checked++;
         if (status !== w.status) begin
            report($sformatf("status %0d, want %0d", status, w.status));
         end
         if (item !== w.item) begin
            report($sformatf("item %0d, want %0d", item, w.item));
         end
         if (fin !== w.final_res) begin
            report($sformatf("final_res %0b, want %0b", fin, w.final_res));
         end
         if (size !== w.size_now) begin
            report($sformatf("size_now %0d, want %0d", size, w.size_now));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = ltfd_pkg::CMD_APPEND;
   ltfd_pkg::data_type req_value = '0;
   logic               req_direction = 1'b0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   ltfd_pkg::data_type rsp_item;
   logic               rsp_final_res;
   logic [5:0]         rsp_size_now;

   list_mirror_type mirror;
   int sender_idle_pct = 0;
   int stall_cycles = 0;

   list_threshold_filter_delete_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_value(req_value),
      .req_direction(req_direction),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_item(rsp_item),
      .rsp_final_res(rsp_final_res),
      .rsp_size_now(rsp_size_now)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         mirror.check_word(rsp_status, rsp_item, rsp_final_res, rsp_size_now);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic ltfd_pkg::data_type pick_value();
      unique case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $urandom_range(1) ? ltfd_pkg::data_type'(0) : ltfd_pkg::data_type'(-1);
         3, 4, 5: return ltfd_pkg::data_type'(int'($urandom_range(16)) - 8);
         default: return ltfd_pkg::data_type'($urandom);
      endcase
   endfunction

   task automatic issue(input logic [1:0] cmd, input ltfd_pkg::data_type val, input logic dir);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_command = cmd;
      req_value = val;
      req_direction = dir;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      mirror.note_command(cmd, val, dir);
   endtask

   task automatic run_random(input int quota);
      int                 sent;
      int                 burst;
      int                 r;
      ltfd_pkg::data_type thr;
      sent = 0;
      // fill up to the top, then push a few words into a full list
      while (mirror.fill_level() < ltfd_pkg::LIST_DEPTH) begin
         issue(ltfd_pkg::CMD_APPEND, pick_value(), 1'($urandom_range(1)));
         sent++;
      end
      burst = $urandom_range(3, 1);
      repeat (burst) issue(ltfd_pkg::CMD_APPEND, pick_value(), 1'($urandom_range(1)));
      sent += burst;
      while (sent < quota) begin
         r = $urandom_range(99);
         if (r < 45) begin
            burst = $urandom_range(6, 1);
            repeat (burst) issue(ltfd_pkg::CMD_APPEND, pick_value(), 1'($urandom_range(1)));
            sent += burst;
         end else if (r < 65) begin
            issue(ltfd_pkg::CMD_READ, pick_value(), 1'($urandom_range(1)));
            sent++;
         end else if (r < 93) begin
            thr = ($urandom_range(9) < 7) ? mirror.sample_entry() : pick_value();
            thr = thr + ltfd_pkg::data_type'(int'($urandom_range(2)) - 1);
            issue(ltfd_pkg::CMD_DELETE, thr, 1'($urandom_range(1)));
            sent++;
         end else begin
            issue(CMD_UNUSED, pick_value(), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      mirror = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list, extremes, removal of the tail entry, unused code
      issue(ltfd_pkg::CMD_READ, 0, 1'b0);
      issue(ltfd_pkg::CMD_DELETE, 0, 1'b0);
      issue(ltfd_pkg::CMD_DELETE, 0, 1'b1);
      issue(CMD_UNUSED, 32'sh1234_5678, 1'b1);
      issue(ltfd_pkg::CMD_APPEND, 32'sh8000_0000, 1'b0);
      issue(ltfd_pkg::CMD_APPEND, 32'sh7fff_ffff, 1'b1);
      issue(ltfd_pkg::CMD_APPEND, 0, 1'b0);
      issue(ltfd_pkg::CMD_APPEND, -1, 1'b0);
      issue(ltfd_pkg::CMD_APPEND, 1, 1'b0);
      issue(ltfd_pkg::CMD_APPEND, 5, 1'b1);
      issue(ltfd_pkg::CMD_READ, 32'sh5555_aaaa, 1'b1);
      issue(ltfd_pkg::CMD_DELETE, -1, ltfd_pkg::DIR_AT_OR_BELOW);
      issue(ltfd_pkg::CMD_DELETE, 5, ~ltfd_pkg::DIR_AT_OR_BELOW);
      issue(ltfd_pkg::CMD_DELETE, 32'sh7fff_ffff, ~ltfd_pkg::DIR_AT_OR_BELOW);
      issue(ltfd_pkg::CMD_READ, 0, 1'b0);
      issue(ltfd_pkg::CMD_DELETE, 32'sh8000_0000, ltfd_pkg::DIR_AT_OR_BELOW);
      issue(ltfd_pkg::CMD_DELETE, 32'sh8000_0000, ~ltfd_pkg::DIR_AT_OR_BELOW);
      issue(ltfd_pkg::CMD_READ, 0, 1'b0);
      issue(ltfd_pkg::CMD_APPEND, 32'shaaaa_5555, 1'b1);
      issue(ltfd_pkg::CMD_APPEND, -3, 1'b0);
      issue(ltfd_pkg::CMD_DELETE, 32'sh7fff_ffff, ltfd_pkg::DIR_AT_OR_BELOW);
      issue(ltfd_pkg::CMD_READ, -1, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 69 : 0;
         run_random(42);
      end

      @(negedge clock);
      start = 1'b0;
      while (mirror.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d commands (%0d filter deletes, %0d full-list drops)",
               mirror.commands_seen, mirror.deletes_seen, mirror.full_drops);
      $display("checked %0d response words, %0d mismatches",
               mirror.words_checked, mirror.errors);
      if (mirror.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/ltfd_pkg.sv
src/ltfd_ram.sv
src/ltfd_cmp.sv
src/list_threshold_filter_delete_unit.sv
verif/tb_list_threshold_filter_delete_unit.sv
